// ===== src/canonical_code_table_top_defines.svh =====
// Assertion macros for the canonical code table block.
// Included by canonical_code_table_top; no other dependencies.
`ifndef CANONICAL_CODE_TABLE_TOP_DEFINES_SVH
`define CANONICAL_CODE_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("canonical code table check failed");
// Next-cycle implication, disabled during reset.
`define CCT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("canonical code table check failed");
`else
`define CCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define CCT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/cct_pkg.sv =====
// Shared types, constants and helper functions for the canonical code table.
// No dependencies; used by cct_ctrl, cct_datapath and canonical_code_table_top.
package cct_pkg;

   // Fixed field widths of the request and response beats.
   localparam int LEN_W  = 5;
   localparam int CODE_W = 16;
   localparam int SYM_W  = 8;

   // Request kinds.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Request beat: a length load or a symbol query.
   typedef struct packed {
      logic             kind;
      logic [LEN_W-1:0] symbol_length;
      logic             last;
      logic [SYM_W-1:0] query_symbol;
   } req_type;

   // Response beat: one per query.
   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  code_length;
      logic [CODE_W-1:0] code_bits;
      logic              used;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;
      logic query_en;
      logic base_init;
      logic base_run;
      logic walk_init;
      logic walk_run;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_room;
      logic base_last;
      logic walk_done;
   } status_type;

   // Mask of the low len bits, saturated at the code width.
   function automatic logic [CODE_W-1:0] len_mask(input logic [5:0] len);
      if (len >= 6'(CODE_W)) begin
         return '1;
      end
      return CODE_W'((CODE_W'(1) << len) - CODE_W'(1));
   endfunction

endpackage

// ===== src/canonical_code_table_top.sv =====
// Top level of the canonical code table: controller plus datapath.
// Depends on cct_pkg, cct_ctrl, cct_datapath and canonical_code_table_top_defines.svh.
//
// Load beats deliver code lengths in symbol order, one per cycle while req_ready is
// high; lengths above MAX_CODE_LENGTH are saturated and loads past SYMBOLS are
// dropped. The load marked last ends the table and starts the build, during which
// req_ready is low: the first code of each length is formed one code length at a
// time, then the walk reads the length memory through its single read port one
// symbol at a time, writes each code and sees the walk finish. Query beats are
// taken one per cycle otherwise, while the query pipe has room, and each response
// passes through the memory read register, then the output register. A symbol at
// or beyond the loaded count, or with length zero, reports used = 0 with zero
// length and code.
`include "canonical_code_table_top_defines.svh"

module canonical_code_table_top #(
   parameter int SYMBOLS         = 256,
   parameter int MAX_CODE_LENGTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cct_pkg::rsp_type rsp_data
);
   import cct_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       build_busy;
   logic       rsp_blank;
   logic       rsp_has_length;

   // Sequencing and handshake.
   cct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd)
   );

   // Memories, counters and the query pipeline.
   cct_datapath #(
      .SYMBOLS         (SYMBOLS),
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Terms used by the checks below.
   assign build_busy     = cmd.base_run || cmd.walk_run;
   assign rsp_blank      = (rsp_data.code_length == '0) && (rsp_data.code_bits == '0);
   assign rsp_has_length = (rsp_data.code_length != '0);

   // No beat may be taken while the table is being built.
   `CCT_ASSERT_IMP(a_build_blocks_input, clock, reset, build_busy, !req_ready)
   // The last load of a table closes the input in the next cycle.
   `CCT_ASSERT_NXT(a_last_load_starts_build, clock, reset, cmd.base_init, !req_ready)
   // An unused symbol reports a blank length and code.
   `CCT_ASSERT_IMP(a_unused_is_blank, clock, reset, rsp_valid && !rsp_data.used, rsp_blank)
   // A used symbol always carries a nonzero length.
   `CCT_ASSERT_IMP(a_used_has_length, clock, reset, rsp_valid && rsp_data.used, rsp_has_length)

endmodule

// ===== src/cct_ctrl.sv =====
// Controller for the canonical code table: handshake and table build sequencing.
// Depends on cct_pkg for the command and status structs.
module cct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cct_pkg::req_type    req_data,
   input  cct_pkg::status_type status,
   output cct_pkg::cmd_type    cmd
);
   import cct_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BASE = 3'b010,
      ST_WALK = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Beats are taken only while no table build runs and the query pipe has room.
   assign req_ready = (state_ff == ST_IDLE) && status.pipe_room;
   assign accept    = req_valid && req_ready;

   // Command decode.
   always_comb begin
      cmd.load_en   = accept && (req_data.kind == KIND_LOAD);
      cmd.query_en  = accept && (req_data.kind == KIND_QUERY);
      cmd.base_init = cmd.load_en && req_data.last;
      cmd.base_run  = (state_ff == ST_BASE);
      cmd.walk_init = (state_ff == ST_BASE) && status.base_last;
      cmd.walk_run  = (state_ff == ST_WALK);
   end

   // Next state: idle, first-code pass over lengths, then the symbol walk.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.base_init) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            if (status.base_last) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/cct_datapath.sv =====
// Datapath for the canonical code table: length and code memories, per-length
// counters, first-code registers, and the query pipeline. Depends on cct_pkg.
module cct_datapath #(
   parameter int SYMBOLS         = 256,
   parameter int MAX_CODE_LENGTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cct_pkg::req_type    req_data,
   input  cct_pkg::cmd_type    cmd,
   output cct_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cct_pkg::rsp_type    rsp_data
);
   import cct_pkg::*;

   localparam int ADDR_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int POS_W  = $clog2(SYMBOLS + 1);
   localparam int LIDX_W = $clog2(MAX_CODE_LENGTH + 1);
   localparam logic [POS_W-1:0]  SYM_LIMIT = POS_W'(SYMBOLS);
   localparam logic [LIDX_W-1:0] LEN_LIMIT = LIDX_W'(MAX_CODE_LENGTH);

   // Storage.
   logic [LEN_W-1:0]  length_mem [SYMBOLS];
   logic [CODE_W-1:0] code_mem   [SYMBOLS];

   // Load bookkeeping.
   logic [POS_W-1:0]  load_pos_ff, load_pos_in;
   logic [POS_W-1:0]  total_ff, total_in;
   logic [POS_W-1:0]  count_ff [MAX_CODE_LENGTH + 1];
   logic [POS_W-1:0]  count_in [MAX_CODE_LENGTH + 1];
   logic              load_room;
   logic              load_first;
   logic [LEN_W-1:0]  load_len;
   logic [POS_W-1:0]  load_pos_next;

   // First-code pass.
   logic [LIDX_W-1:0] len_ctr_ff, len_ctr_in;
   logic [CODE_W-1:0] running_ff, running_in;
   logic [CODE_W-1:0] next_ff [MAX_CODE_LENGTH + 1];
   logic [CODE_W-1:0] next_in [MAX_CODE_LENGTH + 1];
   logic [POS_W-1:0]  prior;
   logic [CODE_W-1:0] base_sum;
   logic [CODE_W-1:0] base_code;

   // Symbol walk.
   logic [POS_W-1:0]  walk_addr_ff, walk_addr_in;
   logic              walk_v_ff;
   logic [ADDR_W-1:0] walk_sym_ff;
   logic [LEN_W-1:0]  w_len_ff;
   logic              walk_rd;
   logic [LIDX_W-1:0] w_idx;
   logic [CODE_W-1:0] w_mask;
   logic [CODE_W-1:0] w_code;

   // Query pipeline.
   logic [ADDR_W-1:0] rd_addr;
   logic              s1_valid_ff;
   logic [SYM_W-1:0]  s1_sym_ff;
   logic              s1_in_ff;
   logic [LEN_W-1:0]  q_len_ff;
   logic [CODE_W-1:0] q_code_ff;
   logic              s1_adv;
   logic              s1_used;
   logic              q_in_range;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // Load: saturate the length, advance the position unless full; rewind on the last.
   assign load_room     = (load_pos_ff != SYM_LIMIT);
   assign load_first    = (load_pos_ff == '0);
   assign load_len      = (int'(req_data.symbol_length) > MAX_CODE_LENGTH) ?
                          LEN_W'(MAX_CODE_LENGTH) : req_data.symbol_length;
   assign load_pos_next = load_pos_ff + POS_W'(load_room);

   always_comb begin
      load_pos_in = load_pos_ff;
      total_in    = total_ff;
      if (cmd.load_en) begin
         if (load_first) begin
            total_in = '0;
         end
         if (req_data.last) begin
            total_in    = load_pos_next;
            load_pos_in = '0;
         end else begin
            load_pos_in = load_pos_next;
         end
      end
   end

   // Per-length counts, cleared by the first load of a table. Length zero is
   // never counted, so its entry stays zero and serves as the prior count of length one.
   always_comb begin
      for (int l = 0; l <= MAX_CODE_LENGTH; l++) begin
         count_in[l] = count_ff[l];
      end
      if (cmd.load_en) begin
         if (load_first) begin
            for (int l = 0; l <= MAX_CODE_LENGTH; l++) begin
               count_in[l] = '0;
            end
         end
         if (load_room && (load_len != '0)) begin
            count_in[LIDX_W'(load_len)] = count_in[LIDX_W'(load_len)] + POS_W'(1);
         end
      end
   end

   // First-code pass: one length per cycle.
   assign prior     = count_ff[LIDX_W'(len_ctr_ff - LIDX_W'(1))];
   assign base_sum  = running_ff + CODE_W'(prior);
   assign base_code = CODE_W'(base_sum << 1) & len_mask(6'(len_ctr_ff));

   // Symbol walk: the datapath processes the length read in the previous cycle.
   assign walk_rd = cmd.walk_run && (walk_addr_ff != total_ff);
   assign w_idx   = LIDX_W'(w_len_ff);
   assign w_mask  = len_mask(6'(w_len_ff));
   assign w_code  = (w_len_ff == '0) ? '0 : (next_ff[w_idx] & w_mask);

   always_comb begin
      len_ctr_in   = len_ctr_ff;
      running_in   = running_ff;
      walk_addr_in = walk_addr_ff;
      for (int l = 0; l <= MAX_CODE_LENGTH; l++) begin
         next_in[l] = next_ff[l];
      end
      if (cmd.base_init) begin
         len_ctr_in = LIDX_W'(1);
         running_in = '0;
         next_in[0] = '0;
      end
      if (cmd.base_run) begin
         running_in          = base_code;
         len_ctr_in          = len_ctr_ff + LIDX_W'(1);
         next_in[len_ctr_ff] = base_code;
      end
      if (cmd.walk_init) begin
         walk_addr_in = '0;
      end
      if (walk_rd) begin
         walk_addr_in = walk_addr_ff + POS_W'(1);
      end
      if (walk_v_ff && (w_len_ff != '0)) begin
         next_in[w_idx] = CODE_W'(next_ff[w_idx] + CODE_W'(1)) & w_mask;
      end
   end

   // Query pipeline control.
   assign s1_adv     = !rsp_valid_ff || rsp_ready;
   assign q_in_range = (int'(req_data.query_symbol) < SYMBOLS) &&
                       (int'(req_data.query_symbol) < int'(total_ff));
   assign s1_used    = s1_in_ff && (q_len_ff != '0);

   // Shared length read port: the walk owns it while the symbol walk runs.
   assign rd_addr = cmd.walk_run ? ADDR_W'(walk_addr_ff) : ADDR_W'(req_data.query_symbol);

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (cmd.load_en && load_room) begin
         length_mem[ADDR_W'(load_pos_ff)] <= load_len;
      end
      if (cmd.query_en) begin
         q_len_ff  <= length_mem[rd_addr];
         q_code_ff <= code_mem[ADDR_W'(req_data.query_symbol)];
      end
      if (walk_rd) begin
         w_len_ff <= length_mem[rd_addr];
      end
      if (walk_v_ff) begin
         code_mem[walk_sym_ff] <= w_code;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      running_ff <= running_in;
      for (int l = 0; l <= MAX_CODE_LENGTH; l++) begin
         next_ff[l] <= next_in[l];
      end
      if (walk_rd) begin
         walk_sym_ff <= ADDR_W'(walk_addr_ff);
      end
      if (cmd.query_en) begin
         s1_sym_ff <= req_data.query_symbol;
         s1_in_ff  <= q_in_range;
      end
      if (s1_valid_ff && s1_adv) begin
         rsp_ff.symbol      <= s1_sym_ff;
         rsp_ff.code_length <= s1_used ? q_len_ff : '0;
         rsp_ff.code_bits   <= s1_used ? q_code_ff : '0;
         rsp_ff.used        <= s1_used;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff  <= '0;
         total_ff     <= '0;
         len_ctr_ff   <= '0;
         walk_addr_ff <= '0;
         walk_v_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l <= MAX_CODE_LENGTH; l++) begin
            count_ff[l] <= '0;
         end
      end else begin
         load_pos_ff  <= load_pos_in;
         total_ff     <= total_in;
         len_ctr_ff   <= len_ctr_in;
         walk_addr_ff <= walk_addr_in;
         walk_v_ff    <= walk_rd;
         s1_valid_ff  <= cmd.query_en || (s1_valid_ff && !s1_adv);
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         for (int l = 0; l <= MAX_CODE_LENGTH; l++) begin
            count_ff[l] <= count_in[l];
         end
      end
   end

   // Status to the controller and the response port.
   assign status.pipe_room = !s1_valid_ff || s1_adv;
   assign status.base_last = (len_ctr_ff == LEN_LIMIT);
   assign status.walk_done = (walk_addr_ff == total_ff) && !walk_v_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

endmodule
